FILE: hdl/polygon_outline_rasterizer_macros.svh
// Assertion helpers; the enclosing module supplies clk_i and rst_ni.
`ifndef POLYGON_OUTLINE_RASTERIZER_MACROS_SVH
`define POLYGON_OUTLINE_RASTERIZER_MACROS_SVH

`define POLYR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define POLYR_NEVER(lbl, cond, msg) \
  `POLYR_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/polyr_pkg.sv
package polyr_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int FRAC_BITS = 16;
  localparam int AW        = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CFG_W     = 9;
  localparam int NW        = 34;           // signed y*one - b
  localparam int UW        = NW - 1;       // its magnitude
  localparam int PW        = 41;           // a * x
  localparam int SW        = PW + 1;       // a * x + b
  localparam int DW        = 40;           // divisor shifted by 8

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_VERTEX = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [6:0] MARK_VALUE = 7'd100;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         vert_x;
    logic [7:0]         vert_y;
    logic signed [31:0] edge_slope;
    logic signed [31:0] edge_intercept;
    logic               last_vertex;
  } req_t;

  typedef struct packed {
    logic [6:0] pixel_value;
    logic       clipped;
  } res_t;

  typedef struct packed {
    logic [7:0]         x0;
    logic [7:0]         y0;
    logic [7:0]         x1;
    logic [7:0]         y1;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } edge_t;

endpackage

FILE: hdl/polyr_ram.sv
module polyr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/polygon_outline_rasterizer.sv
// Polygon outline rasterizer. Issue a word with start while busy is low; exactly
// one result word follows, shown on result_o for the single cycle that done_o
// is high, and the receiver must take it then. Request words: clear (bitmap and
// polygon), add vertex (draws the edge from the previous vertex, plus the
// closing edge when last_vertex is set), read pixel (100 if marked, else 0).
// Timing: after reset and for every clear request the 1-bit bitmap memory is
// swept once, one entry a cycle; no word is accepted then. A read checks the
// range, then takes the bitmap data. A vertex works per drawn edge: each x-pass
// pixel does a slope multiply, then add and range check; each horizontal or
// vertical run pixel is marked directly; each y-pass pixel does numerator,
// magnitudes, range check, then an 8-step restoring divide (the divide is
// skipped when the range check drops the mark, and a flat slope skips all
// but the first step); each edge adds two pass setups and the edge end. Marks
// are registered and written to the bitmap in the cycle after they are
// produced; results are flagged clipped when a mark fell outside the image or
// was dropped, or a read fell outside it. Image size registers are at byte 0
// (width) and 4 (height); only low 9 bits count, values above 256 saturate.
module polygon_outline_rasterizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  polyr_pkg::req_t   req_i,
  output logic              done_o,
  output polyr_pkg::res_t   result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import polyr_pkg::*;
  `include "polygon_outline_rasterizer_macros.svh"

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_PA   = 4'd2;   // first pass setup
  localparam logic [3:0] S_RUNA = 4'd3;   // vertical run
  localparam logic [3:0] S_XMUL = 4'd4;
  localparam logic [3:0] S_XSUM = 4'd5;
  localparam logic [3:0] S_PB   = 4'd6;   // second pass setup
  localparam logic [3:0] S_RUNB = 4'd7;   // horizontal run
  localparam logic [3:0] S_YN   = 4'd8;
  localparam logic [3:0] S_YABS = 4'd9;
  localparam logic [3:0] S_YCHK = 4'd10;
  localparam logic [3:0] S_YDIV = 4'd11;
  localparam logic [3:0] S_EEND = 4'd12;
  localparam logic [3:0] S_RD   = 4'd13;
  localparam logic [3:0] S_RDW  = 4'd14;

  localparam logic [CFG_W-1:0] SIDE_MAX = CFG_W'(MAX_SIDE);

  logic [3:0]         state_q, state_d;
  req_t               in_q, in_d;
  edge_t              cur_q, cur_d, nxt_q, nxt_d;
  logic               nxt_vld_q, nxt_vld_d;
  logic [7:0]         first_x_q, first_x_d, first_y_q, first_y_d;
  logic               have_prev_q, have_prev_d;
  edge_t              prev_q, prev_d;   // x0/y0 hold the previous vertex
  logic [7:0]         j_q, j_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [NW-1:0] n_q, n_d;
  logic [UW-1:0]      un_q, un_d, rem_q, rem_d;
  logic [31:0]        ud_q, ud_d;
  logic               negc_q, negc_d;
  logic [DW-1:0]      dsh_q, dsh_d;
  logic [7:0]         quo_q, quo_d;
  logic [2:0]         k_q, k_d;
  logic               clip_q, clip_d;
  logic               mark_vld_q, mark_vld_d;
  logic [7:0]         mark_x_q, mark_x_d, mark_y_q, mark_y_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               clr_res_q, clr_res_d;
  logic [CFG_W-1:0]   w_q, h_q;

  // edge geometry
  logic [7:0] xl, xh, yl, yh;
  assign xl = (cur_q.x0 < cur_q.x1) ? cur_q.x0 : cur_q.x1;
  assign xh = (cur_q.x0 < cur_q.x1) ? cur_q.x1 : cur_q.x0;
  assign yl = (cur_q.y0 < cur_q.y1) ? cur_q.y0 : cur_q.y1;
  assign yh = (cur_q.y0 < cur_q.y1) ? cur_q.y1 : cur_q.y0;

  // mark request from the sequencer
  logic       mk_en, mk_fit, mk_inr;
  logic [7:0] mk_x, mk_y;
  assign mk_inr = mk_fit && ({1'b0, mk_x} < w_q) && ({1'b0, mk_y} < h_q);

  logic signed [SW-1:0] xsum;
  logic [NW-1:0]        yshift;
  logic                 div_ge;
  logic [7:0]           quo_nx;
  logic                 rd_inr;
  logic                 ram_rdata;

  assign xsum   = SW'(prod_q) + SW'(cur_q.b);
  assign yshift = {{(NW-8-FRAC_BITS){1'b0}}, j_q, {FRAC_BITS{1'b0}}};
  assign div_ge = {{(DW-UW){1'b0}}, rem_q} >= dsh_q;
  assign quo_nx = {quo_q[6:0], div_ge};
  assign rd_inr = ({1'b0, in_q.vert_x} < w_q) && ({1'b0, in_q.vert_y} < h_q);

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    nxt_vld_d   = nxt_vld_q;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    j_d         = j_q;
    prod_d      = prod_q;
    n_d         = n_q;
    un_d        = un_q;
    ud_d        = ud_q;
    negc_d      = negc_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    k_d         = k_q;
    clip_d      = clip_q;
    clr_cnt_d   = clr_cnt_q;
    clr_res_d   = clr_res_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mk_en       = 1'b0;
    mk_fit      = 1'b1;
    mk_x        = j_q;
    mk_y        = j_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          in_d   = req_i;
          clip_d = 1'b0;
          case (req_i.req_type)
            REQ_CLEAR: begin
              first_x_d   = '0;
              first_y_d   = '0;
              prev_d      = '0;
              have_prev_d = 1'b0;
              clr_cnt_d   = '0;
              clr_res_d   = 1'b1;
              state_d     = S_CLR;
            end
            REQ_VERTEX: begin
              // closing edge runs from this vertex back to the first one
              nxt_d.x0 = req_i.vert_x;
              nxt_d.y0 = req_i.vert_y;
              nxt_d.x1 = have_prev_q ? first_x_q : req_i.vert_x;
              nxt_d.y1 = have_prev_q ? first_y_q : req_i.vert_y;
              nxt_d.a  = req_i.edge_slope;
              nxt_d.b  = req_i.edge_intercept;
              if (have_prev_q) begin
                cur_d.x0  = prev_q.x0;
                cur_d.y0  = prev_q.y0;
                cur_d.x1  = req_i.vert_x;
                cur_d.y1  = req_i.vert_y;
                cur_d.a   = prev_q.a;
                cur_d.b   = prev_q.b;
                nxt_vld_d = req_i.last_vertex;
                state_d   = S_PA;
              end else begin
                first_x_d = req_i.vert_x;
                first_y_d = req_i.vert_y;
                nxt_vld_d = 1'b0;
                if (req_i.last_vertex) begin
                  cur_d   = nxt_d;
                  state_d = S_PA;
                end else begin
                  done_d = 1'b1;
                  res_d  = '0;
                end
              end
              have_prev_d = !req_i.last_vertex;
              prev_d.x0   = req_i.vert_x;
              prev_d.y0   = req_i.vert_y;
              prev_d.a    = req_i.edge_slope;
              prev_d.b    = req_i.edge_intercept;
            end
            REQ_READ: begin
              state_d = S_RD;
            end
            default: begin
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = S_IDLE;
          if (clr_res_q) begin
            done_d = 1'b1;
            res_d  = '0;
          end
        end
      end
      S_PA: begin
        if (cur_q.x0 == cur_q.x1) begin
          j_d     = yl;
          state_d = (yl < yh) ? S_RUNA : S_PB;
        end else if (cur_q.y0 != cur_q.y1) begin
          j_d     = xl;
          state_d = S_XMUL;
        end else begin
          state_d = S_PB;
        end
      end
      S_RUNA: begin
        mk_en = 1'b1;
        mk_x  = cur_q.x0;
        j_d   = j_q + 1'b1;
        if (j_q + 8'd1 == yh) begin
          state_d = S_PB;
        end
      end
      S_XMUL: begin
        prod_d  = cur_q.a * $signed({1'b0, j_q});
        state_d = S_XSUM;
      end
      S_XSUM: begin
        mk_en  = 1'b1;
        mk_fit = (xsum[SW-1:FRAC_BITS+8] == '0);
        mk_y   = xsum[FRAC_BITS+7:FRAC_BITS];
        j_d    = j_q + 1'b1;
        state_d = (j_q == xh) ? S_PB : S_XMUL;
      end
      S_PB: begin
        if (cur_q.y0 == cur_q.y1) begin
          j_d     = xl;
          state_d = (xl < xh) ? S_RUNB : S_EEND;
        end else if (cur_q.x0 != cur_q.x1) begin
          j_d     = yl;
          state_d = S_YN;
        end else begin
          state_d = S_EEND;
        end
      end
      S_RUNB: begin
        mk_en = 1'b1;
        mk_y  = cur_q.y0;
        j_d   = j_q + 1'b1;
        if (j_q + 8'd1 == xh) begin
          state_d = S_EEND;
        end
      end
      S_YN: begin
        if (cur_q.a == '0) begin
          // no column for a flat slope: every y-pass mark is dropped
          clip_d  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = (j_q == yh) ? S_EEND : S_YN;
        end else begin
          n_d     = $signed(yshift) - NW'(cur_q.b);
          state_d = S_YABS;
        end
      end
      S_YABS: begin
        un_d    = n_q[NW-1] ? UW'(-n_q) : UW'(n_q);
        ud_d    = cur_q.a[31] ? 32'(-cur_q.a) : 32'(cur_q.a);
        negc_d  = (n_q[NW-1] != cur_q.a[31]) && (n_q != '0);
        state_d = S_YCHK;
      end
      S_YCHK: begin
        // negative or >= 256 quotient can never land in the image
        if (negc_q || ({{(DW-UW){1'b0}}, un_q} >= {ud_q, 8'b0})) begin
          clip_d  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = (j_q == yh) ? S_EEND : S_YN;
        end else begin
          rem_d   = un_q;
          dsh_d   = {1'b0, ud_q, 7'b0};
          quo_d   = '0;
          k_d     = '0;
          state_d = S_YDIV;
        end
      end
      S_YDIV: begin
        rem_d = div_ge ? UW'({{(DW-UW){1'b0}}, rem_q} - dsh_q) : rem_q;
        dsh_d = dsh_q >> 1;
        quo_d = quo_nx;
        k_d   = k_q + 1'b1;
        if (&k_q) begin
          mk_en   = 1'b1;
          mk_x    = quo_nx;
          j_d     = j_q + 1'b1;
          state_d = (j_q == yh) ? S_EEND : S_YN;
        end
      end
      S_EEND: begin
        if (nxt_vld_q) begin
          cur_d     = nxt_q;
          nxt_vld_d = 1'b0;
          state_d   = S_PA;
        end else begin
          done_d  = 1'b1;
          res_d   = '{pixel_value: '0, clipped: clip_q};
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        if (rd_inr) begin
          state_d = S_RDW;
        end else begin
          done_d  = 1'b1;
          res_d   = '{pixel_value: '0, clipped: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_RDW: begin
        done_d  = 1'b1;
        res_d   = '{pixel_value: (ram_rdata ? MARK_VALUE : 7'd0), clipped: 1'b0};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // mark: in range goes to the write stage, else flag
    mark_vld_d = 1'b0;
    mark_x_d   = mark_x_q;
    mark_y_d   = mark_y_q;
    if (mk_en) begin
      if (mk_inr) begin
        mark_vld_d = 1'b1;
        mark_x_d   = mk_x;
        mark_y_d   = mk_y;
      end else begin
        clip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      nxt_vld_q   <= 1'b0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      clip_q      <= 1'b0;
      mark_vld_q  <= 1'b0;
      done_q      <= 1'b0;
      clr_cnt_q   <= '0;
      clr_res_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_vld_q   <= nxt_vld_d;
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      clip_q      <= clip_d;
      mark_vld_q  <= mark_vld_d;
      done_q      <= done_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_res_q   <= clr_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    j_q      <= j_d;
    prod_q   <= prod_d;
    n_q      <= n_d;
    un_q     <= un_d;
    ud_q     <= ud_d;
    negc_q   <= negc_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    quo_q    <= quo_d;
    k_q      <= k_d;
    mark_x_q <= mark_x_d;
    mark_y_q <= mark_y_d;
    res_q    <= res_d;
  end

  // config registers, saturated to the bitmap side
  logic [CFG_W-1:0] cfg_v;
  logic             cfg_wr;
  assign cfg_v  = (pwdata[CFG_W-1:0] > SIDE_MAX) ? SIDE_MAX : pwdata[CFG_W-1:0];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= SIDE_MAX;
      h_q <= SIDE_MAX;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        h_q <= cfg_v;
      end else begin
        w_q <= cfg_v;
      end
    end
  end

  assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] ? h_q : w_q)};
  assign pready = 1'b1;

  // bitmap memory: one write port shared by clear sweep and marks
  logic          clr_act;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  assign clr_act   = (state_q == S_CLR);
  assign ram_we    = clr_act || mark_vld_q;
  assign ram_waddr = clr_act ? clr_cnt_q
                   : AW'(17'(mark_y_q) * 17'(w_q) + 17'(mark_x_q));
  assign ram_raddr = AW'(17'(in_q.vert_y) * 17'(w_q) + 17'(in_q.vert_x));

  polyr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (!clr_act),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // a nonzero pixel word is always a clean in-image hit
  logic pix_ok;
  assign pix_ok = (result_o.pixel_value == MARK_VALUE) && !result_o.clipped;

  `POLYR_NEVER(a_no_wr_clash, clr_act && mark_vld_q, "mark write during clear sweep")
  `POLYR_ASSERT(a_done_idle, done_o |-> !busy, "result word while still busy")
  `POLYR_ASSERT(a_pix_val, done_o && (result_o.pixel_value != 7'd0) |-> pix_ok, "bad pixel word")
  `POLYR_ASSERT(a_rd_seq, (state_q == S_RDW) |-> $past(state_q == S_RD), "read data without read")

endmodule

FILE: dv/tb_polygon_outline_rasterizer.sv
`timescale 1ns / 100ps

module tb_polygon_outline_rasterizer;
  import polyr_pkg::*;

  // request code 3 has no function; the block must answer 0, 0 and keep its state
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;
  localparam int         IDLE_LIMIT  = 250000;  // longer than the clear sweep

  // Outline model: keeps its own bitmap and polygon state and queues the
  // result word every accepted request should produce.
  class raster_scoreboard;
    bit                 marks [MAX_SIDE*MAX_SIDE];
    int unsigned        img_w = 256, img_h = 256;
    logic [7:0]         first_x, first_y, last_x, last_y;
    logic signed [31:0] last_a, last_b;
    bit                 open_poly;
    bit                 dropped;
    res_t               want_q[$];
    int                 errors;

    function void set_size(logic [2:0] addr, logic [31:0] val);
      int unsigned v;
      v = 32'(val[CFG_W-1:0]);
      if (v > MAX_SIDE) v = MAX_SIDE;
      if (addr == ADDR_WIDTH) img_w = v;
      else if (addr == ADDR_HEIGHT) img_h = v;
    endfunction

    function void plot(longint x, longint y);
      if (x < 0 || y < 0 || x >= img_w || y >= img_h) begin
        dropped = 1;
        return;
      end
      marks[16'(y * img_w + x)] = 1;
    endfunction

    // floor of n/d, d nonzero
    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return q;
    endfunction

    function void trace_edge(int x0, int y0, int x1, int y1, longint a, longint b);
      int xl, xh, yl, yh;
      longint one;
      one = longint'(1) << FRAC_BITS;
      xl = x0 < x1 ? x0 : x1;  xh = x0 < x1 ? x1 : x0;
      yl = y0 < y1 ? y0 : y1;  yh = y0 < y1 ? y1 : y0;
      if (x0 == x1) begin
        for (int j = yl; j < yh; j++) plot(longint'(x0), longint'(j));
      end else if (y0 != y1) begin
        for (int j = xl; j <= xh; j++) plot(longint'(j), floor_quot(a * j + b, one));
      end
      if (y0 == y1) begin
        for (int j = xl; j < xh; j++) plot(longint'(j), longint'(y0));
      end else if (x0 != x1) begin
        for (int j = yl; j <= yh; j++) begin
          if (a == 0) dropped = 1;
          else plot(floor_quot(longint'(j) * one - b, a), longint'(j));
        end
      end
    endfunction

    function void note_word(req_t r);
      res_t w;
      w = '0;
      dropped = 0;
      case (r.req_type)
        REQ_CLEAR: begin
          foreach (marks[i]) marks[i] = 0;
          first_x = '0; first_y = '0; last_x = '0; last_y = '0;
          last_a = '0; last_b = '0; open_poly = 0;
        end
        REQ_VERTEX: begin
          if (open_poly) trace_edge(int'(last_x), int'(last_y), int'(r.vert_x),
                                    int'(r.vert_y), longint'(last_a), longint'(last_b));
          else begin
            first_x = r.vert_x;
            first_y = r.vert_y;
          end
          if (r.last_vertex) begin
            trace_edge(int'(r.vert_x), int'(r.vert_y), int'(first_x), int'(first_y),
                       longint'(r.edge_slope), longint'(r.edge_intercept));
            open_poly = 0;
          end else open_poly = 1;
          last_x = r.vert_x;  last_y = r.vert_y;
          last_a = r.edge_slope;  last_b = r.edge_intercept;
        end
        REQ_READ: begin
          if (r.vert_x < img_w && r.vert_y < img_h) begin
            if (marks[16'(r.vert_y * img_w + r.vert_x)]) w.pixel_value = MARK_VALUE;
          end else dropped = 1;
        end
        default: ;
      endcase
      w.clipped = dropped;
      want_q.push_back(w);
    endfunction

    function void check_result(res_t got);
      res_t w;
      if (want_q.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.pixel_value !== w.pixel_value) begin
        $error("pixel_value: expected %0d, actual %0d", w.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.clipped !== w.clipped) begin
        $error("clipped: expected %0d, actual %0d", w.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        start, busy;
  req_t        req_i;
  logic        done_o;
  res_t        result_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  raster_scoreboard sb = new();
  int  idle_cycles;
  bit  burst;  // when set, the sender issues back to back

  polygon_outline_rasterizer uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // results cannot be stalled: take every strobed word at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // watchdog: cycles with neither a word accepted nor a result produced
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_polygon_outline_rasterizer failed");
      $finish;
    end
  end

  // Issue one word. start stays high across a zero gap so it is never
  // dropped and raised within the same step.
  task automatic send_word(req_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_word(r);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    do @(posedge clk_i); while (busy);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_size(addr, val);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [1:0] kind, int x, int y, logic [31:0] a,
                              logic [31:0] b, bit fin);
    req_t r;
    r.req_type = kind;  r.vert_x = 8'(x);  r.vert_y = 8'(y);
    r.edge_slope = a;   r.edge_intercept = b;  r.last_vertex = fin;
    return r;
  endfunction

  // vertex whose slope and intercept roughly follow the edge to the next point, or are random
  function automatic req_t vertex_to(int x0, int y0, int x1, int y1, bit fin);
    longint a, b;
    if (x1 == x0 || $urandom_range(0, 9) == 0) return mk(REQ_VERTEX, x0, y0,
        $urandom, $urandom, fin);
    a = ((longint'(y1) - y0) <<< FRAC_BITS) / (longint'(x1) - x0);
    b = (longint'(y0) <<< FRAC_BITS) - a * x0 + $urandom_range(0, 65535);
    return mk(REQ_VERTEX, x0, y0, a[31:0], b[31:0], fin);
  endfunction

  // random polygons, mostly small, with reads around them and some noise
  task automatic random_phase(int count);
    int ox, oy, span, nv, vx[8], vy[8];
    for (int n = 0; n < count; ) begin
      burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) begin
        ox = 0; oy = 0; span = 255;
      end else begin
        span = $urandom_range(1, 12);
        ox = $urandom_range(0, 255 - span);
        oy = $urandom_range(0, 255 - span);
      end
      nv = $urandom_range(1, 6);
      for (int i = 0; i < nv; i++) begin
        vx[i] = ox + $urandom_range(0, span);
        vy[i] = oy + $urandom_range(0, span);
      end
      for (int i = 0; i < nv; i++) begin
        send_word(vertex_to(vx[i], vy[i], vx[(i + 1) % nv], vy[(i + 1) % nv],
                            i == nv - 1));
        n++;
      end
      repeat ($urandom_range(1, 6)) begin
        send_word(mk(REQ_READ, ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                     $urandom, $urandom, 1'($urandom_range(0, 1))));
        n++;
      end
      if ($urandom_range(0, 3) == 0) begin
        // noise: anything the fields allow, clear kept rare since it sweeps all 64k entries
        send_word(mk($urandom_range(0, 9) == 0 ? REQ_CLEAR : 2'($urandom_range(1, 3)),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom, $urandom, 1'($urandom_range(0, 1))));
        n++;
      end
    end
    burst = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start <= 1'b0;  req_i <= '0;
    psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;  paddr <= '0;  pwdata <= '0;
    burst = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(ADDR_WIDTH, 32'd256);
    write_reg(ADDR_HEIGHT, 32'd256);

    // directed: corners, unused code, triangle, vertical, horizontal,
    // zero slope, degenerate edge, lone last vertex, extreme slopes, clear
    send_word(mk(REQ_READ, 0, 0, '0, '0, 0));
    send_word(mk(REQ_READ, 255, 255, '1, '1, 1));
    send_word(mk(REQ_UNUSED, 255, 255, '1, '1, 1));
    send_word(vertex_to(10, 10, 20, 15, 0));
    send_word(vertex_to(20, 15, 14, 25, 0));
    send_word(vertex_to(14, 25, 10, 10, 1));
    send_word(mk(REQ_READ, 10, 10, '0, '0, 0));
    send_word(mk(REQ_READ, 15, 12, '0, '0, 0));
    send_word(mk(REQ_VERTEX, 30, 5, 32'h0001_0000, '0, 0));
    send_word(mk(REQ_VERTEX, 30, 12, 32'h0001_0000, '0, 1));
    send_word(mk(REQ_READ, 30, 5, '0, '0, 0));
    send_word(mk(REQ_VERTEX, 40, 40, '0, 32'h0028_0000, 0));
    send_word(mk(REQ_VERTEX, 50, 40, '0, 32'h0028_0000, 1));
    send_word(mk(REQ_VERTEX, 60, 60, '0, 32'h003C_8000, 0));
    send_word(mk(REQ_VERTEX, 70, 70, '0, 32'h003C_8000, 1));
    send_word(mk(REQ_VERTEX, 80, 80, 32'h0001_0000, '0, 0));
    send_word(mk(REQ_VERTEX, 80, 80, 32'h0001_0000, '0, 1));
    send_word(mk(REQ_VERTEX, 90, 90, 32'h0002_0000, 32'hFFFF_0000, 1));
    send_word(mk(REQ_VERTEX, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_word(mk(REQ_VERTEX, 255, 255, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    send_word(mk(REQ_READ, 60, 60, '0, '0, 0));
    send_word(mk(REQ_CLEAR, 0, 0, '0, '0, 0));
    send_word(mk(REQ_READ, 10, 10, '0, '0, 0));

    random_phase(130);
    drain();
    // narrow image; old marks reinterpreted with the new stride
    write_reg(ADDR_WIDTH, 32'd17);
    write_reg(ADDR_HEIGHT, 32'd9);
    random_phase(90);
    drain();
    // zero width drops everything
    write_reg(ADDR_WIDTH, 32'd0);
    write_reg(ADDR_HEIGHT, 32'd5);
    random_phase(50);
    drain();
    // oversize values saturate to full size
    write_reg(ADDR_WIDTH, 32'hFFFF_FF2C);
    write_reg(ADDR_HEIGHT, 32'd511);
    random_phase(110);
    drain();
    write_reg(ADDR_WIDTH, 32'd1);
    write_reg(ADDR_HEIGHT, 32'd1);
    random_phase(50);
    drain();
    write_reg(ADDR_WIDTH, 32'd256);
    write_reg(ADDR_HEIGHT, 32'd200);
    random_phase(130);

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("tb_polygon_outline_rasterizer passed");
    end else begin
      $display("tb_polygon_outline_rasterizer failed");
    end
    $finish;
  end

endmodule
